FILE: design/qgtl_pkg.sv
// ----------------------------------------------------------------------------
// qgtl_pkg
// Shared types, codes and defaults of the quantized grid table lookup.
// ----------------------------------------------------------------------------
package qgtl_pkg;

   localparam int DEF_TABLE_DEPTH = 4096;
   localparam int DEF_VALUE_WIDTH = 32;
   localparam int DEF_NUM_DIMS    = 3;

   localparam int COORD_W   = 32;
   localparam int RECIP_W   = 32;
   localparam int COUNT_W   = 13;
   localparam int BASE_W    = 12;
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;
   localparam int NUM_COLS  = 4;
   localparam int DIM_W     = 2;

   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OOB        = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_V    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_IRR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_TEMP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_V    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_IRR  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_TEMP = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ROW   = 3'd6;

   localparam logic [RECIP_W-1:0] RECIP_RESET = 32'd65536;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd1;
   localparam logic [BASE_W-1:0]  BASE_RESET  = 12'd1;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic signed [COORD_W-1:0] volt_value;
      logic signed [COORD_W-1:0] irr_value;
      logic signed [COORD_W-1:0] temp_value;
      logic signed [COORD_W-1:0] current_value;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_volt;
      logic signed [COORD_W-1:0] out_irr;
      logic signed [COORD_W-1:0] out_temp;
      logic signed [COORD_W-1:0] out_current;
      logic [STATUS_W-1:0]       status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_QMUL,
      S_QCHK,
      S_HORN,
      S_ROWCHK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic qmul;
      logic qchk;
      logic horn;
      logic rowchk;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic req_lookup;
      logic oob;
      logic last_dim;
   } sts_type;

endpackage

FILE: design/qgtl_ram.sv
// ----------------------------------------------------------------------------
// qgtl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qgtl_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/qgtl_ctrl.sv
// ----------------------------------------------------------------------------
// qgtl_ctrl
// Sequencer: accepts a transaction, steps a lookup through quantize,
// index accumulation and row read, then hands the result to the output slot.
// ----------------------------------------------------------------------------
module qgtl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  qgtl_pkg::sts_type sts,
   output qgtl_pkg::cmd_type cmd
);

   qgtl_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qgtl_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         qgtl_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.req_lookup ? qgtl_pkg::S_QMUL : qgtl_pkg::S_DONE;
            end
         end
         qgtl_pkg::S_QMUL: begin
            cmd.qmul = 1'b1;
            state_in = qgtl_pkg::S_QCHK;
         end
         qgtl_pkg::S_QCHK: begin
            cmd.qchk = 1'b1;
            state_in = sts.oob ? qgtl_pkg::S_DONE : qgtl_pkg::S_HORN;
         end
         qgtl_pkg::S_HORN: begin
            cmd.horn = 1'b1;
            state_in = sts.last_dim ? qgtl_pkg::S_ROWCHK : qgtl_pkg::S_QMUL;
         end
         qgtl_pkg::S_ROWCHK: begin
            cmd.rowchk = 1'b1;
            state_in   = qgtl_pkg::S_DONE;
         end
         qgtl_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = qgtl_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = qgtl_pkg::S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == qgtl_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/qgtl_dp.sv
// ----------------------------------------------------------------------------
// qgtl_dp
// Datapath: configuration registers, row count, shared quantize multiplier,
// row-major index accumulator, row store and result register.
// ----------------------------------------------------------------------------
module qgtl_dp #(
   parameter int TABLE_DEPTH = qgtl_pkg::DEF_TABLE_DEPTH,
   parameter int VALUE_WIDTH = qgtl_pkg::DEF_VALUE_WIDTH,
   parameter int NUM_DIMS    = qgtl_pkg::DEF_NUM_DIMS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  qgtl_pkg::req_type                 req_data,
   output qgtl_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   input  logic [qgtl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [qgtl_pkg::CSR_DAT_W-1:0]    csr_wdata,
   input  qgtl_pkg::cmd_type                 cmd,
   output qgtl_pkg::sts_type                 sts
);

   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ACC_W  = NUM_DIMS * qgtl_pkg::COUNT_W;
   localparam int ROW_W  = ACC_W + 1;
   localparam int CMP_W  = (ROW_W > CNT_W) ? ROW_W : CNT_W;
   localparam int MEM_W  = qgtl_pkg::NUM_COLS * VALUE_WIDTH;
   localparam int PROD_W = qgtl_pkg::COORD_W + qgtl_pkg::RECIP_W;
   localparam int HP_W   = ACC_W + qgtl_pkg::COUNT_W;

   logic [qgtl_pkg::RECIP_W-1:0] recip_ff [3];
   logic [qgtl_pkg::COUNT_W-1:0] count_ff [3];
   logic [qgtl_pkg::BASE_W-1:0]  base_ff;

   qgtl_pkg::req_type            req_ff;
   logic [CNT_W-1:0]             rows_ff, rows_in;
   logic [qgtl_pkg::DIM_W-1:0]   dim_ff;
   logic [PROD_W-1:0]            prod_ff;
   logic                         neg_ff;
   logic [qgtl_pkg::COUNT_W-1:0] idx_ff;
   logic [ACC_W-1:0]             acc_ff;
   logic [qgtl_pkg::STATUS_W-1:0] status_ff;
   logic                         hit_ff;
   qgtl_pkg::rsp_type            rsp_ff;

   logic [qgtl_pkg::RECIP_W-1:0] recip_sel;
   logic [qgtl_pkg::COUNT_W-1:0] count_sel;
   logic [qgtl_pkg::COORD_W-1:0] coord_sel;
   logic [qgtl_pkg::COORD_W-1:0] mag;
   logic [PROD_W-1:0]            rounded;
   logic [qgtl_pkg::COORD_W-1:0] qidx;
   logic [HP_W-1:0]              horn_prod;
   logic [CMP_W-1:0]             row_ext;
   logic                         full;
   logic                         miss;
   logic                         wr_en;
   logic [MEM_W-1:0]             wr_data;
   logic [MEM_W-1:0]             rd_data;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            recip_ff[i] <= qgtl_pkg::RECIP_RESET;
            count_ff[i] <= qgtl_pkg::COUNT_RESET;
         end
         base_ff <= qgtl_pkg::BASE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            qgtl_pkg::CSR_RECIP_V:    recip_ff[0] <= csr_wdata;
            qgtl_pkg::CSR_RECIP_IRR:  recip_ff[1] <= csr_wdata;
            qgtl_pkg::CSR_RECIP_TEMP: recip_ff[2] <= csr_wdata;
            qgtl_pkg::CSR_COUNT_V:    count_ff[0] <= csr_wdata[qgtl_pkg::COUNT_W-1:0];
            qgtl_pkg::CSR_COUNT_IRR:  count_ff[1] <= csr_wdata[qgtl_pkg::COUNT_W-1:0];
            qgtl_pkg::CSR_COUNT_TEMP: count_ff[2] <= csr_wdata[qgtl_pkg::COUNT_W-1:0];
            qgtl_pkg::CSR_BASE_ROW:   base_ff     <= csr_wdata[qgtl_pkg::BASE_W-1:0];
            default: ;
         endcase
      end
   end

   // per-dimension selection
   always_comb begin
      unique case (dim_ff)
         2'd0:    coord_sel = req_ff.volt_value;
         2'd1:    coord_sel = req_ff.irr_value;
         default: coord_sel = req_ff.temp_value;
      endcase
   end

   assign recip_sel = recip_ff[(dim_ff > 2'd2) ? 2'd2 : dim_ff];
   assign count_sel = count_ff[(dim_ff > 2'd2) ? 2'd2 : dim_ff];
   assign mag       = coord_sel[qgtl_pkg::COORD_W-1] ? (~coord_sel + 1'b1) : coord_sel;

   // round half away from zero on the magnitude
   assign rounded = prod_ff + PROD_W'(64'h8000_0000);
   assign qidx    = rounded[PROD_W-1 -: qgtl_pkg::COORD_W];

   assign horn_prod = acc_ff * count_sel;
   assign row_ext   = CMP_W'(acc_ff) + CMP_W'(base_ff);
   assign miss      = row_ext >= CMP_W'(rows_ff);
   assign full      = rows_ff >= CNT_W'(TABLE_DEPTH);

   assign sts.req_lookup = (req_data.mode == qgtl_pkg::MODE_LOOKUP);
   assign sts.oob        = (neg_ff && qidx != '0) ||
                           (qidx >= qgtl_pkg::COORD_W'(count_sel));
   assign sts.last_dim   = (dim_ff == qgtl_pkg::DIM_W'(NUM_DIMS - 1));

   assign wr_en   = cmd.accept && req_data.mode == qgtl_pkg::MODE_APPEND && !full;
   assign wr_data = {VALUE_WIDTH'(req_data.volt_value), VALUE_WIDTH'(req_data.irr_value),
                     VALUE_WIDTH'(req_data.temp_value), VALUE_WIDTH'(req_data.current_value)};

   always_comb begin
      rows_in = rows_ff;
      if (cmd.accept) begin
         if (wr_en) begin
            rows_in = rows_ff + 1'b1;
         end else if (req_data.mode == qgtl_pkg::MODE_CLEAR) begin
            rows_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= '0;
         dim_ff    <= '0;
         acc_ff    <= '0;
         hit_ff    <= 1'b0;
         status_ff <= qgtl_pkg::ST_OK;
      end else begin
         rows_ff <= rows_in;
         if (cmd.accept) begin
            dim_ff    <= '0;
            acc_ff    <= '0;
            hit_ff    <= 1'b0;
            status_ff <= (req_data.mode == qgtl_pkg::MODE_APPEND && full) ?
                         qgtl_pkg::ST_FULL : qgtl_pkg::ST_OK;
         end
         if (cmd.qchk && sts.oob) begin
            status_ff <= qgtl_pkg::ST_OOB;
         end
         if (cmd.horn) begin
            acc_ff <= horn_prod[ACC_W-1:0] + ACC_W'(idx_ff);
            dim_ff <= dim_ff + 1'b1;
         end
         if (cmd.rowchk) begin
            if (miss) begin
               status_ff <= qgtl_pkg::ST_NOT_LOADED;
            end else begin
               hit_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.qmul) begin
         prod_ff <= mag * recip_sel;
         neg_ff  <= coord_sel[qgtl_pkg::COORD_W-1];
      end
      if (cmd.qchk) begin
         idx_ff <= neg_ff ? '0 : qidx[qgtl_pkg::COUNT_W-1:0];
      end
      if (cmd.load_rsp) begin
         if (hit_ff) begin
            rsp_ff.out_volt    <= qgtl_pkg::COORD_W'(rd_data[3*VALUE_WIDTH +: VALUE_WIDTH]);
            rsp_ff.out_irr     <= qgtl_pkg::COORD_W'(rd_data[2*VALUE_WIDTH +: VALUE_WIDTH]);
            rsp_ff.out_temp    <= qgtl_pkg::COORD_W'(rd_data[VALUE_WIDTH +: VALUE_WIDTH]);
            rsp_ff.out_current <= qgtl_pkg::COORD_W'(rd_data[0 +: VALUE_WIDTH]);
         end else begin
            rsp_ff.out_volt    <= '0;
            rsp_ff.out_irr     <= '0;
            rsp_ff.out_temp    <= '0;
            rsp_ff.out_current <= '0;
         end
         rsp_ff.status <= status_ff;
      end
   end

   assign rsp_data = rsp_ff;

   qgtl_ram #(
      .WIDTH (MEM_W),
      .DEPTH (TABLE_DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rows_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.rowchk && !miss),
      .rd_addr (row_ext[AW-1:0]),
      .rd_data (rd_data)
   );

endmodule

FILE: design/quantized_grid_table_lookup.sv
// ----------------------------------------------------------------------------
// quantized_grid_table_lookup
// Row table with append, clear and quantized row-major grid lookup.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready carrying mode and four Q16.16
// columns; each produces exactly one response on rsp_valid/rsp_ready.
// Append and clear go from acceptance straight to the done state, which
// loads the response register and raises rsp_valid. A lookup runs each grid
// dimension through one shared 32x32 quantize multiplier, a bounds check and
// one index multiply-accumulate, then a row check and row-store read before
// the done state; it ends early when a coordinate is out of bounds.
// One transaction is in flight at a time; req_ready is high only while idle.
// The response sits in an output register, so a new request is accepted
// while an earlier response waits; a stalled receiver holds the next
// result in the sequencer until the register frees.
// Configuration writes on csr_valid/csr_index/csr_wdata are always taken;
// the user must make them only while no transaction is in flight (unenforced).
// Reset empties the table and restores register defaults; the row store
// needs no clearing pass since rows at or above the row count are never read.
// ----------------------------------------------------------------------------
module quantized_grid_table_lookup #(
   parameter int TABLE_DEPTH = qgtl_pkg::DEF_TABLE_DEPTH,
   parameter int VALUE_WIDTH = qgtl_pkg::DEF_VALUE_WIDTH,
   parameter int NUM_DIMS    = qgtl_pkg::DEF_NUM_DIMS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  qgtl_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output qgtl_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [qgtl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qgtl_pkg::CSR_DAT_W-1:0] csr_wdata
);

   qgtl_pkg::cmd_type cmd;
   qgtl_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   qgtl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   qgtl_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIMS    (NUM_DIMS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
